// File: design/evl_pkg.sv
// evl_pkg: shared types and codes for the event list scheduler.
// Holds the item structs, the slot entry type, and the cell control codes.
// No dependencies.
package evl_pkg;

  localparam int TIME_W = 32;
  localparam int TYPE_W = 8;
  localparam int PAY_W  = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;

  // commands
  localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SETCLK   = 2'd3;

  // result status
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_LATE     = 2'd3;

  // per-cycle cell operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_SHIFT  = 2'd2;
  localparam logic [1:0] CELL_ROTATE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] event_time;
    logic [TYPE_W-1:0] evt_code;
    logic [PAY_W-1:0]  payload;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TIME_W-1:0] out_time;
    logic [TYPE_W-1:0] out_type;
    logic [PAY_W-1:0]  out_payload;
    logic [TIME_W-1:0] clock_now;
    logic [TYPE_W-1:0] next_kind;
    logic [LEN_W-1:0]  list_length;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [TYPE_W-1:0] ev_type;
    logic [PAY_W-1:0]  ev_pay;
  } entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [1:0] op;
    entry_t     ins;
    entry_t     head;
  } cell_ctl_t;

endpackage

// File: design/evl_cell.sv
// evl_cell: one slot of the sorted event list.
// Holds one entry and moves it to or from its neighbors as the controller asks.
// Depends on evl_pkg.
module evl_cell (
  input  logic               clk,
  input  evl_pkg::cell_ctl_t ctl_i,
  input  logic               occ_i,
  input  logic               tail_i,
  input  evl_pkg::entry_t    left_i,
  input  logic               left_after_i,
  input  evl_pkg::entry_t    right_i,
  output evl_pkg::entry_t    ent_o,
  output logic               after_o
);

  evl_pkg::entry_t ent_r;
  evl_pkg::entry_t ent_nxt;

  // at or past the insert point: empty, or strictly later than the new time
  assign after_o = !occ_i || (ent_r.ev_time > ctl_i.ins.ev_time);
  assign ent_o   = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    unique case (ctl_i.op)
      evl_pkg::CELL_HOLD: begin
        ent_nxt = ent_r;
      end
      evl_pkg::CELL_INSERT: begin
        if (after_o) begin
          ent_nxt = left_after_i ? left_i : ctl_i.ins;
        end
      end
      evl_pkg::CELL_SHIFT: begin
        ent_nxt = right_i;
      end
      evl_pkg::CELL_ROTATE: begin
        ent_nxt = tail_i ? ctl_i.head : right_i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// File: design/event_list_scheduler.sv
// Event list scheduler: schedule, advance and set clock return their result in the
// cycle after the start beat; one such command per cycle while no cancel is busy.
// Cancel rotates the list past the head comparator, one entry per cycle: busy
// while each entry held passes the head once, result at the end; empty list: no scan.
// Reset (rst_n low, synchronous) clears entry count, clock, last kind and control;
// slot contents are not cleared. The receiver cannot stall the result strobe.
module event_list_scheduler #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  evl_pkg::in_item_t   in_item,
  output logic                out_valid,
  output evl_pkg::out_item_t  out_item
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                        state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               remain_r, remain_nxt;
  logic [evl_pkg::TIME_W-1:0]  clock_r, clock_nxt;
  logic [evl_pkg::TYPE_W-1:0]  kind_r, kind_nxt;
  logic [evl_pkg::TYPE_W-1:0]  key_r, key_nxt;
  logic                        found_r, found_nxt;
  evl_pkg::entry_t             held_r, held_nxt;
  logic                        out_valid_r, out_valid_nxt;
  evl_pkg::out_item_t          out_r, out_nxt;

  evl_pkg::cell_ctl_t          ctl;
  evl_pkg::entry_t             ent   [QUEUE_DEPTH];
  logic                        after [QUEUE_DEPTH];
  evl_pkg::entry_t             head;
  logic                        accept;
  logic                        hit;

  assign head   = ent[0];
  assign busy   = (state_r == ST_SCAN);
  assign accept = start && !busy;
  assign hit    = !found_r && (head.ev_type == key_r);

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic            occ;
      logic            tail;
      evl_pkg::entry_t left_e;
      evl_pkg::entry_t right_e;
      logic            left_after;

      assign occ  = CW'(gi) < count_r;
      assign tail = CW'(gi) == (count_r - CW'(1));

      if (gi == 0) begin : g_first
        assign left_e     = ctl.ins;
        assign left_after = 1'b0;
      end else begin : g_mid
        assign left_e     = ent[gi-1];
        assign left_after = after[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign right_e = ent[gi];
      end else begin : g_inner
        assign right_e = ent[gi+1];
      end

      evl_cell u_cell (
        .clk          (clk),
        .ctl_i        (ctl),
        .occ_i        (occ),
        .tail_i       (tail),
        .left_i       (left_e),
        .left_after_i (left_after),
        .right_i      (right_e),
        .ent_o        (ent[gi]),
        .after_o      (after[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    clock_nxt     = clock_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    held_nxt      = held_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    ctl.op        = evl_pkg::CELL_HOLD;
    ctl.ins.ev_time = in_item.event_time;
    ctl.ins.ev_type = in_item.evt_code;
    ctl.ins.ev_pay  = in_item.payload;
    ctl.head      = head;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt             = '0;
          out_nxt.status      = evl_pkg::ST_OK;
          unique case (in_item.command)
            evl_pkg::CMD_SCHEDULE: begin
              out_valid_nxt = 1'b1;
              if (count_r == CW'(QUEUE_DEPTH)) begin
                out_nxt.status = evl_pkg::ST_FULL;
              end else begin
                ctl.op    = evl_pkg::CELL_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            evl_pkg::CMD_ADVANCE: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                out_nxt.status = evl_pkg::ST_NOTFOUND;
              end else begin
                ctl.op              = evl_pkg::CELL_SHIFT;
                count_nxt           = count_r - CW'(1);
                out_nxt.out_time    = head.ev_time;
                out_nxt.out_type    = head.ev_type;
                out_nxt.out_payload = head.ev_pay;
                if (head.ev_time < clock_r) begin
                  out_nxt.status = evl_pkg::ST_LATE;
                end else begin
                  clock_nxt = head.ev_time;
                  kind_nxt  = head.ev_type;
                end
              end
            end
            evl_pkg::CMD_CANCEL: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = evl_pkg::ST_NOTFOUND;
              end else begin
                state_nxt  = ST_SCAN;
                remain_nxt = count_r;
                key_nxt    = in_item.evt_code;
                found_nxt  = 1'b0;
              end
            end
            evl_pkg::CMD_SETCLK: begin
              out_valid_nxt = 1'b1;
              clock_nxt     = in_item.event_time;
            end
          endcase
          out_nxt.clock_now   = clock_nxt;
          out_nxt.next_kind   = kind_nxt;
          out_nxt.list_length = evl_pkg::LEN_W'(count_nxt);
        end
      end
      ST_SCAN: begin
        // head is compared each cycle; first match drops out, others go to the tail
        remain_nxt = remain_r - CW'(1);
        if (hit) begin
          ctl.op    = evl_pkg::CELL_SHIFT;
          count_nxt = count_r - CW'(1);
          found_nxt = 1'b1;
          held_nxt  = head;
        end else begin
          ctl.op = evl_pkg::CELL_ROTATE;
        end
        if (remain_r == CW'(1)) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          if (found_nxt) begin
            out_nxt.status      = evl_pkg::ST_OK;
            out_nxt.out_time    = held_nxt.ev_time;
            out_nxt.out_type    = held_nxt.ev_type;
            out_nxt.out_payload = held_nxt.ev_pay;
          end else begin
            out_nxt.status = evl_pkg::ST_NOTFOUND;
          end
          out_nxt.clock_now   = clock_r;
          out_nxt.next_kind   = kind_r;
          out_nxt.list_length = evl_pkg::LEN_W'(count_nxt);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      clock_r     <= '0;
      kind_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      clock_r     <= clock_nxt;
      kind_r      <= kind_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    held_r <= held_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_scan_remain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> (remain_r != '0 && remain_r <= count_r + CW'(1)))
    else $error("scan counter out of range");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.command != evl_pkg::CMD_CANCEL |=> out_valid_r && !busy)
    else $error("single-cycle command gave no result beat");

  a_no_result_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result beat while cancel scan is running");

endmodule

// File: test/tb_event_list_scheduler.sv
// Testbench for event_list_scheduler: directed table, then phased random commands.
// Each result is checked against a hand-written expectation or a behavioral model of the sorted event list.
// Depends on evl_pkg and the event_list_scheduler RTL.
module tb_event_list_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 1150;
  localparam int STALL_LIMIT  = 2000;

  typedef struct {
    evl_pkg::in_item_t  item;
    bit                 typed;
    evl_pkg::out_item_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  evl_pkg::in_item_t  in_item;
  logic               out_valid;
  evl_pkg::out_item_t out_item;

  // hand-written expectation that travels with a directed beat
  logic               note_valid;
  evl_pkg::out_item_t note_want;

  // model state
  evl_pkg::entry_t    sched_list[$];
  logic [evl_pkg::TIME_W-1:0] sim_clock;
  logic [evl_pkg::TYPE_W-1:0] last_taken_kind;

  evl_pkg::out_item_t pending_results[$];
  dir_row_t           dir_rows[$];

  int errors;
  int n_items;
  int n_full;
  int n_late;
  int n_cancel_hit;
  int n_miss;
  int peak_len;
  int idle_cycles;

  event_list_scheduler #(.QUEUE_DEPTH(LIST_DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Model of one command: updates the list, clock and last kind, returns the result.
  function automatic evl_pkg::out_item_t apply_command(evl_pkg::in_item_t cmd);
    evl_pkg::out_item_t res;
    evl_pkg::entry_t    e;
    int                 pos;
    res = '0;
    res.status = evl_pkg::ST_OK;
    case (cmd.command)
      evl_pkg::CMD_SCHEDULE: begin
        if (sched_list.size() >= LIST_DEPTH) begin
          res.status = evl_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < sched_list.size() && cmd.event_time >= sched_list[pos].ev_time)
            pos++;
          e.ev_time = cmd.event_time;
          e.ev_type = cmd.evt_code;
          e.ev_pay  = cmd.payload;
          sched_list.insert(pos, e);
        end
      end
      evl_pkg::CMD_ADVANCE: begin
        if (sched_list.size() == 0) begin
          res.status = evl_pkg::ST_NOTFOUND;
        end else begin
          e = sched_list.pop_front();
          res.out_time    = e.ev_time;
          res.out_type    = e.ev_type;
          res.out_payload = e.ev_pay;
          if (e.ev_time < sim_clock) begin
            res.status = evl_pkg::ST_LATE;
          end else begin
            sim_clock       = e.ev_time;
            last_taken_kind = e.ev_type;
          end
        end
      end
      evl_pkg::CMD_CANCEL: begin
        pos = 0;
        while (pos < sched_list.size() && sched_list[pos].ev_type != cmd.evt_code)
          pos++;
        if (pos < sched_list.size()) begin
          e = sched_list[pos];
          sched_list.delete(pos);
          res.out_time    = e.ev_time;
          res.out_type    = e.ev_type;
          res.out_payload = e.ev_pay;
        end else begin
          res.status = evl_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        sim_clock = cmd.event_time;
      end
    endcase
    res.clock_now   = sim_clock;
    res.next_kind   = last_taken_kind;
    res.list_length = evl_pkg::LEN_W'(sched_list.size());
    return res;
  endfunction

  function automatic evl_pkg::out_item_t mk_out(logic [evl_pkg::STAT_W-1:0] st,
                                                logic [evl_pkg::TIME_W-1:0] t,
                                                logic [evl_pkg::TYPE_W-1:0] ty,
                                                logic [evl_pkg::PAY_W-1:0] p,
                                                logic [evl_pkg::TIME_W-1:0] clk_now,
                                                logic [evl_pkg::TYPE_W-1:0] kind, int len);
    evl_pkg::out_item_t r;
    r.status      = st;
    r.out_time    = t;
    r.out_type    = ty;
    r.out_payload = p;
    r.clock_now   = clk_now;
    r.next_kind   = kind;
    r.list_length = evl_pkg::LEN_W'(len);
    return r;
  endfunction

  task automatic add_row(logic [evl_pkg::CMD_W-1:0] c, logic [evl_pkg::TIME_W-1:0] t,
                         logic [evl_pkg::TYPE_W-1:0] ty, logic [evl_pkg::PAY_W-1:0] p,
                         bit typed, evl_pkg::out_item_t want);
    dir_row_t r;
    r.item.command    = c;
    r.item.event_time = t;
    r.item.evt_code   = ty;
    r.item.payload    = p;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  function automatic int pick_gap(bit no_idle);
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one beat and hold it until the block takes it.
  task automatic send(evl_pkg::in_item_t it, bit typed, evl_pkg::out_item_t want, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_item    <= it;
    note_valid <= typed;
    note_want  <= want;
    do @(posedge clk); while (busy);
  endtask

  // Random command shaped by phase: 0 fills the list, 1 drains it, 2 mixes.
  function automatic evl_pkg::in_item_t make_item(int phase);
    evl_pkg::in_item_t it;
    int r;
    int w_sched;
    int w_adv;
    int w_cancel;
    case (phase)
      0:       begin w_sched = 80; w_adv = 88; w_cancel = 96; end
      1:       begin w_sched = 15; w_adv = 60; w_cancel = 95; end
      default: begin w_sched = 40; w_adv = 70; w_cancel = 95; end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_sched)       it.command = evl_pkg::CMD_SCHEDULE;
    else if (r < w_adv)    it.command = evl_pkg::CMD_ADVANCE;
    else if (r < w_cancel) it.command = evl_pkg::CMD_CANCEL;
    else                   it.command = evl_pkg::CMD_SETCLK;

    r = $urandom_range(0, 9);
    if (r < 2)      it.event_time = $urandom;
    else if (r < 7) it.event_time = sim_clock + $urandom_range(0, 20);
    else if (r < 9) it.event_time = $urandom_range(0, 15) * 8;
    else            it.event_time = sim_clock - $urandom_range(1, 50);

    if ($urandom_range(0, 9) < 7) it.evt_code = evl_pkg::TYPE_W'($urandom_range(0, 7));
    else                          it.evt_code = evl_pkg::TYPE_W'($urandom_range(0, 255));
    // cancels mostly aim at a type that is in the list
    if (it.command == evl_pkg::CMD_CANCEL && sched_list.size() != 0 &&
        $urandom_range(0, 3) != 0)
      it.evt_code = sched_list[$urandom_range(0, sched_list.size() - 1)].ev_type;
    it.payload = $urandom;
    return it;
  endfunction

  task automatic field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got)
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
  endtask

  // result check and acceptance monitor
  always @(posedge clk) begin
    evl_pkg::out_item_t want;
    evl_pkg::out_item_t model;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat %h", $time, out_item);
        end else begin
          want = pending_results.pop_front();
          if (out_item !== want) begin
            errors++;
            field_diff("status",      32'(want.status),      32'(out_item.status));
            field_diff("out_time",    want.out_time,          out_item.out_time);
            field_diff("out_type",    32'(want.out_type),     32'(out_item.out_type));
            field_diff("out_payload", want.out_payload,       out_item.out_payload);
            field_diff("clock_now",   want.clock_now,         out_item.clock_now);
            field_diff("next_kind",   32'(want.next_kind),    32'(out_item.next_kind));
            field_diff("list_length", 32'(want.list_length),  32'(out_item.list_length));
          end
        end
      end
      if (start && !busy) begin
        model = apply_command(in_item);
        pending_results.push_back(note_valid ? note_want : model);
        n_items++;
        case (model.status)
          evl_pkg::ST_FULL:     n_full++;
          evl_pkg::ST_LATE:     n_late++;
          evl_pkg::ST_NOTFOUND: n_miss++;
          default:              if (in_item.command == evl_pkg::CMD_CANCEL) n_cancel_hit++;
        endcase
        if (sched_list.size() > peak_len)
          peak_len = sched_list.size();
      end
    end
  end

  // watchdog: too long without any beat on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("** event_list_scheduler: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    evl_pkg::in_item_t  it;
    evl_pkg::out_item_t none;
    int                 phase;
    bit                 no_idle;
    none = '0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    note_valid = 1'b0;
    note_want  = '0;
    sim_clock       = '0;
    last_taken_kind = '0;
    errors = 0; n_items = 0; n_full = 0; n_late = 0;
    n_cancel_hit = 0; n_miss = 0; peak_len = 0;

    // empty list, extremes, equal times, late pops, cancel hit and miss
    add_row(evl_pkg::CMD_ADVANCE,  32'h0,        8'h00, 32'h0, 1,
            mk_out(evl_pkg::ST_NOTFOUND, 0, 0, 0, 0, 0, 0));
    add_row(evl_pkg::CMD_CANCEL,   32'h0,        8'h55, 32'h0, 1,
            mk_out(evl_pkg::ST_NOTFOUND, 0, 0, 0, 0, 0, 0));
    add_row(evl_pkg::CMD_SCHEDULE, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF, 1,
            mk_out(evl_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
    add_row(evl_pkg::CMD_SCHEDULE, 32'h0,        8'h00, 32'h0, 1,
            mk_out(evl_pkg::ST_OK, 0, 0, 0, 0, 0, 2));
    add_row(evl_pkg::CMD_SCHEDULE, 32'd100,      8'h11, 32'hA5A5A5A5, 1,
            mk_out(evl_pkg::ST_OK, 0, 0, 0, 0, 0, 3));
    add_row(evl_pkg::CMD_SCHEDULE, 32'd100,      8'h22, 32'h5A5A5A5A, 0, none);
    add_row(evl_pkg::CMD_ADVANCE,  32'h0,        8'h00, 32'h0, 1,
            mk_out(evl_pkg::ST_OK, 0, 0, 0, 0, 0, 3));
    add_row(evl_pkg::CMD_ADVANCE,  32'h0,        8'h00, 32'h0, 1,
            mk_out(evl_pkg::ST_OK, 100, 8'h11, 32'hA5A5A5A5, 100, 8'h11, 2));
    add_row(evl_pkg::CMD_SETCLK,   32'h200,      8'h00, 32'h0, 1,
            mk_out(evl_pkg::ST_OK, 0, 0, 0, 32'h200, 8'h11, 2));
    add_row(evl_pkg::CMD_ADVANCE,  32'h0,        8'h00, 32'h0, 1,
            mk_out(evl_pkg::ST_LATE, 100, 8'h22, 32'h5A5A5A5A, 32'h200, 8'h11, 1));
    add_row(evl_pkg::CMD_SCHEDULE, 32'h10,       8'h33, 32'h1, 0, none);
    add_row(evl_pkg::CMD_CANCEL,   32'h0,        8'hFF, 32'h0, 1,
            mk_out(evl_pkg::ST_OK, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF, 32'h200, 8'h11, 1));
    add_row(evl_pkg::CMD_CANCEL,   32'h0,        8'h77, 32'h0, 0, none);
    add_row(evl_pkg::CMD_SETCLK,   32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF, 1,
            mk_out(evl_pkg::ST_OK, 0, 0, 0, 32'hFFFFFFFF, 8'h11, 1));
    add_row(evl_pkg::CMD_ADVANCE,  32'h0,        8'h00, 32'h0, 1,
            mk_out(evl_pkg::ST_LATE, 32'h10, 8'h33, 32'h1, 32'hFFFFFFFF, 8'h11, 0));
    add_row(evl_pkg::CMD_SETCLK,   32'h0,        8'h00, 32'h0, 0, none);
    add_row(evl_pkg::CMD_SCHEDULE, 32'd5,        8'h80, 32'h80000000, 0, none);
    add_row(evl_pkg::CMD_SCHEDULE, 32'd5,        8'h01, 32'h7FFFFFFF, 0, none);
    add_row(evl_pkg::CMD_SCHEDULE, 32'd3,        8'h02, 32'h12345678, 0, none);
    add_row(evl_pkg::CMD_CANCEL,   32'h0,        8'h01, 32'h0, 0, none);
    add_row(evl_pkg::CMD_ADVANCE,  32'h0,        8'h00, 32'h0, 0, none);
    add_row(evl_pkg::CMD_ADVANCE,  32'h0,        8'h00, 32'h0, 0, none);
    add_row(evl_pkg::CMD_ADVANCE,  32'h0,        8'h00, 32'h0, 0, none);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want, pick_gap(i < 8));

    phase   = 0;
    no_idle = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0)
        phase = (i == 0) ? 0 : $urandom_range(0, 2);
      if (i % 100 == 0)
        no_idle = ($urandom_range(0, 3) == 0);
      it = make_item(phase);
      send(it, 1'b0, none, pick_gap(no_idle));
    end
    start      <= 1'b0;
    note_valid <= 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d commands: %0d list-full, %0d late pops, %0d cancel hits, %0d misses.",
             n_items, n_full, n_late, n_cancel_hit, n_miss);
    $display("Deepest list seen: %0d entries; %0d result errors.", peak_len, errors);
    if (errors == 0)
      $display("** event_list_scheduler: PASSED **");
    else
      $display("** event_list_scheduler: FAILED **");
    $finish;
  end

endmodule
